[hdl/fan_thermostat_alert_reporter_defines.svh]
// Assertion macros shared by the fan thermostat alert reporter RTL.
// The macros assume a clock named clk and an active-low reset named rst_n.
`ifndef FAN_THERMOSTAT_ALERT_REPORTER_DEFINES_SVH
`define FAN_THERMOSTAT_ALERT_REPORTER_DEFINES_SVH
`ifndef SYNTHESIS
`define FTAR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ftar assertion failed");
`define FTAR_NEVER(lbl, expr) `FTAR_ASSERT(lbl, !(expr))
`else
`define FTAR_ASSERT(lbl, prop)
`define FTAR_NEVER(lbl, expr)
`endif
`endif

[hdl/ftar_pkg.sv]
// Package for the fan thermostat alert reporter: item, result and config types,
// fixed thresholds and small helper functions. No dependencies.
package ftar_pkg;

    // Item codes carried in the op field.
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_POWER  = 2'd1,
        OP_SPEED  = 2'd2,
        OP_AUTO   = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_HOLD_TEMP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_TEMP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_REPORT_DELTA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_REPORT_DELTA  = 3'd4;
    localparam int unsigned CFG_DATA_W = 12;

    // Fixed thresholds in tenths of a degree and speeds in percent.
    localparam logic signed [11:0] TEMP_FULL   = 12'sd350;
    localparam logic signed [11:0] TEMP_RAMP   = 12'sd300;
    localparam logic signed [11:0] RAMP_OFFSET = 12'sd250;
    localparam logic signed [11:0] CLASS_HOT   = 12'sd300;
    localparam logic signed [11:0] CLASS_COLD  = 12'sd200;
    localparam logic [6:0] HOLD_SPEED = 7'd50;
    localparam logic [6:0] MAX_SPEED  = 7'd100;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    // Temperature classes.
    localparam logic [1:0] CLASS_IS_COLD   = 2'd0;
    localparam logic [1:0] CLASS_IS_NORMAL = 2'd1;
    localparam logic [1:0] CLASS_IS_HOT    = 2'd2;

    typedef struct packed {
        logic signed [11:0] fan_hold_temp;
        logic signed [11:0] alert_temp;
        logic [7:0]         report_interval;
        logic [10:0]        temp_report_delta;
        logic [9:0]         hum_report_delta;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic               read_ok;
        logic signed [11:0] temperature;
        logic [9:0]         humidity;
        logic [6:0]         command_value;
    } item_t;

    typedef struct packed {
        logic [6:0]         fan_speed;
        logic [7:0]         fan_duty;
        logic               manual_mode;
        logic               speed_changed;
        logic               alert_on;
        logic               alert_raised;
        logic               alert_cleared;
        logic               report;
        logic signed [11:0] report_temperature;
        logic [9:0]         report_humidity;
        logic [1:0]         temp_class;
    } result_t;

    // Duty = speed * 255 / 100, truncated. The divide by 100 is a multiply by
    // 5243 and a shift by 19, exact for dividends below 43699.
    function automatic logic [7:0] duty_of(input logic [6:0] speed);
        logic [14:0] scaled;
        logic [27:0] prod;
        begin
            scaled = {speed, 8'b0} - {8'b0, speed};
            prod   = 28'(scaled) * 28'd5243;
            duty_of = prod[26:19];
        end
    endfunction

    // Hot, normal or cold class of a reported temperature.
    function automatic logic [1:0] class_of(input logic signed [11:0] temp);
        begin
            if (temp >= CLASS_HOT) begin
                class_of = CLASS_IS_HOT;
            end else if (temp >= CLASS_COLD) begin
                class_of = CLASS_IS_NORMAL;
            end else begin
                class_of = CLASS_IS_COLD;
            end
        end
    endfunction

endpackage

[hdl/ftar_in_if.sv]
// Input channel of the fan thermostat alert reporter: one sample or command per beat.
// Standalone interface, no dependencies.
interface ftar_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic               read_ok;
    logic signed [11:0] temperature;
    logic [9:0]         humidity;
    logic [6:0]         command_value;

    modport source (output valid, op, read_ok, temperature, humidity, command_value,
                    input ready);
    modport sink   (input valid, op, read_ok, temperature, humidity, command_value,
                    output ready);
endinterface

[hdl/ftar_out_if.sv]
// Result channel of the fan thermostat alert reporter: one result per beat.
// Standalone interface, no dependencies.
interface ftar_out_if;
    logic               valid;
    logic               ready;
    logic [6:0]         fan_speed;
    logic [7:0]         fan_duty;
    logic               manual_mode;
    logic               speed_changed;
    logic               alert_on;
    logic               alert_raised;
    logic               alert_cleared;
    logic               report;
    logic signed [11:0] report_temperature;
    logic [9:0]         report_humidity;
    logic [1:0]         temp_class;

    modport source (output valid, fan_speed, fan_duty, manual_mode, speed_changed,
                    alert_on, alert_raised, alert_cleared, report,
                    report_temperature, report_humidity, temp_class,
                    input ready);
    modport sink   (input valid, fan_speed, fan_duty, manual_mode, speed_changed,
                    alert_on, alert_raised, alert_cleared, report,
                    report_temperature, report_humidity, temp_class,
                    output ready);
endinterface

[hdl/ftar_cfg_if.sv]
// Configuration write channel of the fan thermostat alert reporter.
// Standalone interface; widths match the register index and data in ftar_pkg.
interface ftar_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/ftar_cfg.sv]
// Configuration register file of the fan thermostat alert reporter.
// Depends on ftar_pkg for register indexes and the cfg_t struct.
module ftar_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [ftar_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [ftar_pkg::CFG_DATA_W-1:0]    wr_data,
    output ftar_pkg::cfg_t                     cfg_out
);

    ftar_pkg::cfg_t cfg_reg;

    // Write decode; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fan_hold_temp     <= 12'sd270;
            cfg_reg.alert_temp        <= 12'sd300;
            cfg_reg.report_interval   <= 8'd30;
            cfg_reg.temp_report_delta <= 11'd5;
            cfg_reg.hum_report_delta  <= 10'd20;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ftar_pkg::CFG_FAN_HOLD_TEMP:     cfg_reg.fan_hold_temp     <= wr_data;
                ftar_pkg::CFG_ALERT_TEMP:        cfg_reg.alert_temp        <= wr_data;
                ftar_pkg::CFG_REPORT_INTERVAL:   cfg_reg.report_interval   <= wr_data[7:0];
                ftar_pkg::CFG_TEMP_REPORT_DELTA: cfg_reg.temp_report_delta <= wr_data[10:0];
                ftar_pkg::CFG_HUM_REPORT_DELTA:  cfg_reg.hum_report_delta  <= wr_data[9:0];
                default: ;
            endcase
        end
    end

    assign cfg_out = cfg_reg;

endmodule

[hdl/ftar_core.sv]
// Thermostat state and combinational step logic of the fan thermostat alert reporter.
// Depends on ftar_pkg and the assertion macros in the defines header.
`include "fan_thermostat_alert_reporter_defines.svh"

module ftar_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  ftar_pkg::item_t  item,
    input  ftar_pkg::cfg_t   cfg,
    output ftar_pkg::result_t result
);

    logic signed [11:0] cur_temp_reg, cur_temp_next;
    logic [9:0]         cur_hum_reg, cur_hum_next;
    logic signed [11:0] last_temp_reg, last_temp_next;
    logic [9:0]         last_hum_reg, last_hum_next;
    logic [7:0]         count_reg, count_next;
    logic [6:0]         speed_reg, speed_next;
    logic               override_reg, override_next;
    logic               alert_reg, alert_next;

    logic signed [11:0] temp_now;
    logic [9:0]         hum_now;
    logic signed [11:0] ramp_speed;
    logic [6:0]         target;
    logic [7:0]         count_inc;
    logic signed [12:0] temp_diff;
    logic [11:0]        temp_abs;
    logic signed [10:0] hum_diff;
    logic [9:0]         hum_abs;
    logic               alert_now;
    logic               report_now;
    logic               changed;

    // Readings a sample works on: the new ones when valid, else the held ones.
    always_comb
    begin
        temp_now = item.read_ok ? item.temperature : cur_temp_reg;
        hum_now  = item.read_ok ? item.humidity : cur_hum_reg;
    end

    // Auto speed target from the temperature the sample works on.
    always_comb
    begin
        ramp_speed = temp_now - ftar_pkg::RAMP_OFFSET;
        if (temp_now >= ftar_pkg::TEMP_FULL)
        begin
            target = ftar_pkg::MAX_SPEED;
        end
        else if (temp_now >= ftar_pkg::TEMP_RAMP)
        begin
            target = ramp_speed[6:0];
        end
        else if (temp_now > cfg.fan_hold_temp && speed_reg != 7'd0)
        begin
            target = ftar_pkg::HOLD_SPEED;
        end
        else
        begin
            target = 7'd0;
        end
    end

    // Report decision: interval reached or a reading moved by its delta.
    always_comb
    begin
        count_inc  = (count_reg == ftar_pkg::COUNT_MAX) ? count_reg : count_reg + 8'd1;
        temp_diff  = {temp_now[11], temp_now} - {last_temp_reg[11], last_temp_reg};
        temp_abs   = temp_diff[12] ? 12'(-temp_diff) : temp_diff[11:0];
        hum_diff   = $signed({1'b0, hum_now}) - $signed({1'b0, last_hum_reg});
        hum_abs    = hum_diff[10] ? 10'(-hum_diff) : hum_diff[9:0];
        alert_now  = temp_now > cfg.alert_temp;
        report_now = (count_inc >= cfg.report_interval)
                  || (temp_abs >= {1'b0, cfg.temp_report_delta})
                  || (hum_abs >= cfg.hum_report_delta);
    end

    // Next state per item code.
    always_comb
    begin
        cur_temp_next  = cur_temp_reg;
        cur_hum_next   = cur_hum_reg;
        last_temp_next = last_temp_reg;
        last_hum_next  = last_hum_reg;
        count_next     = count_reg;
        speed_next     = speed_reg;
        override_next  = override_reg;
        alert_next     = alert_reg;
        changed        = 1'b0;
        unique case (item.op)
            ftar_pkg::OP_SAMPLE:
            begin
                cur_temp_next = temp_now;
                cur_hum_next  = hum_now;
                if (!override_reg)
                begin
                    speed_next = target;
                    changed    = target != speed_reg;
                end
                alert_next = alert_now;
                if (report_now)
                begin
                    last_temp_next = temp_now;
                    last_hum_next  = hum_now;
                    count_next     = 8'd0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            ftar_pkg::OP_POWER:
            begin
                override_next = 1'b1;
                if (item.command_value == 7'd0)
                begin
                    speed_next = 7'd0;
                end
                else if (speed_reg == 7'd0)
                begin
                    speed_next = ftar_pkg::HOLD_SPEED;
                end
            end
            ftar_pkg::OP_SPEED:
            begin
                override_next = 1'b1;
                speed_next    = (item.command_value > ftar_pkg::MAX_SPEED) ?
                                ftar_pkg::MAX_SPEED : item.command_value;
            end
            ftar_pkg::OP_AUTO:
            begin
                override_next = item.command_value == 7'd0;
            end
            default: ;
        endcase
    end

    // State update on each item taken from the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_temp_reg  <= '0;
            cur_hum_reg   <= '0;
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
            count_reg     <= '0;
            speed_reg     <= '0;
            override_reg  <= 1'b0;
            alert_reg     <= 1'b0;
        end
        else if (fire)
        begin
            cur_temp_reg  <= cur_temp_next;
            cur_hum_reg   <= cur_hum_next;
            last_temp_reg <= last_temp_next;
            last_hum_reg  <= last_hum_next;
            count_reg     <= count_next;
            speed_reg     <= speed_next;
            override_reg  <= override_next;
            alert_reg     <= alert_next;
        end
    end

    // Result of this item, built from the updated state.
    always_comb
    begin
        result.fan_speed          = speed_next;
        result.fan_duty           = ftar_pkg::duty_of(speed_next);
        result.manual_mode        = override_next;
        result.speed_changed      = changed;
        result.alert_on           = alert_next;
        result.alert_raised       = alert_next && !alert_reg;
        result.alert_cleared      = !alert_next && alert_reg;
        result.report             = (item.op == ftar_pkg::OP_SAMPLE) && report_now;
        result.report_temperature = last_temp_next;
        result.report_humidity    = last_hum_next;
        result.temp_class         = ftar_pkg::class_of(last_temp_next);
    end

    // The speed never leaves the percent range.
    `FTAR_NEVER(a_speed_range, speed_reg > ftar_pkg::MAX_SPEED)
    // A report restarts the sample count.
    `FTAR_ASSERT(a_report_clears_count, fire && result.report |=> count_reg == 8'd0)
    // Commands leave the alert level and the reported readings alone.
    `FTAR_ASSERT(a_cmd_keeps_alert,
        fire && item.op != ftar_pkg::OP_SAMPLE |=> $stable(alert_reg) && $stable(last_temp_reg))

endmodule

[hdl/fan_thermostat_alert_reporter.sv]
// Top level of the fan thermostat alert reporter: input stage, step logic, result register.
// Depends on ftar_pkg, the channel interfaces, ftar_cfg, ftar_core and the defines header.
//
// Usage:
//   sample_in  - one sensor sample or fan command per beat (valid/ready).
//   result_out - exactly one result beat per accepted item, in order.
//   cfg        - writes by index; always ready; user writes only while idle (not enforced).
// An accepted item lands in the input register and then steps into the result register,
// from which its result beat is offered; a stall on result_out can hold it in between.
// Throughput: one item per cycle while result_out is ready; the thermostat state is
// read and rewritten by the step logic as each item steps, so the next item sees the
// updated state directly.
// Reset: rst_n clears both pipeline stages and the thermostat state (auto mode,
// speed 0, readings 0, no alert) and loads the register defaults.
// Stall: while result_out is not ready the result register holds its beat;
// one more item can still be taken into the input register, after which
// sample_in.ready drops until the result is taken.
`include "fan_thermostat_alert_reporter_defines.svh"

module fan_thermostat_alert_reporter (
    input  logic          clk,
    input  logic          rst_n,
    ftar_in_if.sink       sample_in,
    ftar_out_if.source    result_out,
    ftar_cfg_if.sink      cfg
);

    logic              in_valid_reg;
    ftar_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    ftar_pkg::result_t out_result_reg;
    ftar_pkg::cfg_t    cfg_cur;
    ftar_pkg::result_t step_result;
    logic              advance;
    logic              fire;

    // Handshake: the step runs when the result register is free or drains.
    assign advance         = !out_valid_reg || result_out.ready;
    assign fire            = in_valid_reg && advance;
    assign sample_in.ready = !in_valid_reg || advance;
    assign cfg.ready       = 1'b1;

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            in_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            in_item_reg.op            <= ftar_pkg::op_t'(sample_in.op);
            in_item_reg.read_ok       <= sample_in.read_ok;
            in_item_reg.temperature   <= sample_in.temperature;
            in_item_reg.humidity      <= sample_in.humidity;
            in_item_reg.command_value <= sample_in.command_value;
        end
    end

    // Configuration registers.
    ftar_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg_out  (cfg_cur)
    );

    // Thermostat state and step logic.
    ftar_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg_cur),
        .result (step_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_result_reg <= step_result;
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.fan_speed          = out_result_reg.fan_speed;
    assign result_out.fan_duty           = out_result_reg.fan_duty;
    assign result_out.manual_mode        = out_result_reg.manual_mode;
    assign result_out.speed_changed      = out_result_reg.speed_changed;
    assign result_out.alert_on           = out_result_reg.alert_on;
    assign result_out.alert_raised       = out_result_reg.alert_raised;
    assign result_out.alert_cleared      = out_result_reg.alert_cleared;
    assign result_out.report             = out_result_reg.report;
    assign result_out.report_temperature = out_result_reg.report_temperature;
    assign result_out.report_humidity    = out_result_reg.report_humidity;
    assign result_out.temp_class         = out_result_reg.temp_class;

    // A waiting item is never dropped while the result side is stalled.
    `FTAR_ASSERT(a_in_holds, in_valid_reg && !advance |=> in_valid_reg)
    // Every stepped item lands in the result register.
    `FTAR_ASSERT(a_fire_to_out, fire |=> out_valid_reg)
    // An empty input stage leaves nothing to step, so no result follows a drain.
    `FTAR_ASSERT(a_no_phantom, !in_valid_reg && advance |=> !out_valid_reg)

endmodule
